// File: rtl/sti_pkg.sv
// Shared package for the sensor table interpolator.
// Field widths, scaling constants, codes and the control/status structs.
// No dependencies.
`default_nettype none

package sti_pkg;

   localparam int STI_MAX_POINTS = 64;

   localparam int COUNT_W    = 7;
   localparam int TEMP_W     = 16;
   localparam int KNOT_W     = 16;
   localparam int INDEX_W    = 6;
   localparam int SAMPLE_W   = 24;
   localparam int UV_W       = 23;
   localparam int PROD_W     = UV_W + TEMP_W;
   localparam int BASE_W     = 25;
   localparam int SUM_W      = BASE_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = 4;

   localparam logic [6:0]        KNOT_SCALE = 7'd100;
   localparam logic [TEMP_W-1:0] TEMP_MAX   = 16'hFFFF;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_TEMP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_TEMP = 2'd2;

   typedef struct packed {
      logic load_x;
      logic knot_wr;
      logic hold_hi;
      logic set_div;
      logic mul_en;
      logic mul_frac;
      logic base_en;
      logic div_init;
      logic div_step;
      logic load_out;
      logic out_err;
   } dp_cmd_type;

   typedef struct packed {
      logic cfg_error;
      logic x_lt_knot;
      logic x_eq_knot;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/sti_datapath.sv
// Datapath: configuration registers, knot memory, multiplier, serial divider
// and result register. Driven by sti_control; uses sti_pkg.
`default_nettype none

module sti_datapath
   import sti_pkg::*;
#(
   parameter int MAX_POINTS = STI_MAX_POINTS,
   parameter int AW         = $clog2(STI_MAX_POINTS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [INDEX_W-1:0]    req_knot_index,
   input  wire logic [KNOT_W-1:0]     req_knot_voltage,
   input  wire logic [SAMPLE_W-1:0]   req_sample_microvolts,
   input  wire dp_cmd_type            cmd,
   input  wire logic [AW-1:0]         rd_addr,
   input  wire logic [AW-1:0]         idx,
   output dp_status_type              status,
   output logic [AW-1:0]              last_idx,
   output logic [TEMP_W-1:0]          rsp_temperature,
   output logic                       rsp_table_error
);

   localparam logic [8:0] MAX9 = 9'(MAX_POINTS);

   logic [KNOT_W-1:0]   mem [MAX_POINTS];
   logic [KNOT_W-1:0]   rd_data_ff;

   logic [COUNT_W-1:0]  count_ff;
   logic [TEMP_W-1:0]   first_ff;
   logic [TEMP_W-1:0]   second_ff;

   logic [SAMPLE_W-1:0] x_ff;
   logic [UV_W-1:0]     hi_ff;
   logic [UV_W-1:0]     div_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [BASE_W-1:0]   base_ff;
   logic [UV_W-1:0]     rem_ff;
   logic [TEMP_W-1:0]   quo_ff;
   logic [TEMP_W-1:0]   temp_ff;
   logic                err_ff;

   logic [8:0]          n9;
   logic [TEMP_W-1:0]   step;
   logic [UV_W-1:0]     cur_uv;
   logic [UV_W-1:0]     hi_minus_x;
   logic [UV_W-1:0]     mul_a;
   logic [UV_W:0]       trial;
   logic                trial_ge;
   logic [UV_W-1:0]     rem_in;
   logic [SUM_W-1:0]    sum;
   logic [TEMP_W-1:0]   temp_sat;
   logic                knot_ok;

   // knot store
   assign knot_ok = 9'(req_knot_index) < MAX9;

   always_ff @(posedge clock) begin
      if (cmd.knot_wr && knot_ok) begin
         mem[AW'(req_knot_index)] <= req_knot_voltage;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POINT_COUNT: count_ff  <= csr_data[COUNT_W-1:0];
            CSR_FIRST_TEMP:  first_ff  <= csr_data[TEMP_W-1:0];
            CSR_SECOND_TEMP: second_ff <= csr_data[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   assign n9       = (9'(count_ff) > MAX9) ? MAX9 : 9'(count_ff);
   assign last_idx = AW'(n9 - 9'd1);
   assign step     = second_ff - first_ff;

   assign status.cfg_error = (count_ff == '0) || (first_ff >= second_ff);

   assign cur_uv           = UV_W'(rd_data_ff) * UV_W'(KNOT_SCALE);
   assign status.x_lt_knot = x_ff < SAMPLE_W'(cur_uv);
   assign status.x_eq_knot = x_ff == SAMPLE_W'(cur_uv);

   // fraction numerator is only formed when x lies below hi
   assign hi_minus_x = hi_ff - x_ff[UV_W-1:0];
   assign mul_a      = cmd.mul_frac ? hi_minus_x : UV_W'(idx);

   assign trial    = {rem_ff, quo_ff[TEMP_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};
   assign rem_in   = trial_ge ? UV_W'(trial - {1'b0, div_ff}) : trial[UV_W-1:0];

   assign sum      = SUM_W'(base_ff) + SUM_W'(quo_ff);
   assign temp_sat = (sum > SUM_W'(TEMP_MAX)) ? TEMP_MAX : sum[TEMP_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= req_sample_microvolts;
      end
      if (cmd.hold_hi) begin
         hi_ff <= cur_uv;
      end
      if (cmd.set_div) begin
         div_ff <= hi_ff - cur_uv;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(step);
      end
      if (cmd.base_en) begin
         base_ff <= BASE_W'(first_ff) + BASE_W'(prod_ff[BASE_W-2:0]);
      end
      if (cmd.base_en) begin
         quo_ff <= '0;
      end else if (cmd.div_init) begin
         quo_ff <= prod_ff[TEMP_W-1:0];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[TEMP_W-2:0], trial_ge};
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[PROD_W-1:TEMP_W];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
      if (cmd.load_out) begin
         temp_ff <= cmd.out_err ? '0 : temp_sat;
         err_ff  <= cmd.out_err;
      end
   end

   assign rsp_temperature = temp_ff;
   assign rsp_table_error = err_ff;

endmodule

`default_nettype wire

// File: rtl/sti_control.sv
// Controller: handshakes, knot search sequencing, multiply and divide steps.
// Commands sti_datapath; uses sti_pkg.
`default_nettype none

module sti_control
   import sti_pkg::*;
#(
   parameter int AW = $clog2(STI_MAX_POINTS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_action,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   input  wire logic [AW-1:0] last_idx,
   output dp_cmd_type         cmd,
   output logic [AW-1:0]      rd_addr,
   output logic [AW-1:0]      idx
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHK_FIRST = 4'd1;
   localparam logic [3:0] ST_CHK_LAST  = 4'd2;
   localparam logic [3:0] ST_SCAN      = 4'd3;
   localparam logic [3:0] ST_MUL_IDX   = 4'd4;
   localparam logic [3:0] ST_ADD_BASE  = 4'd5;
   localparam logic [3:0] ST_MUL_FRAC  = 4'd6;
   localparam logic [3:0] ST_DIV_INIT  = 4'd7;
   localparam logic [3:0] ST_DIV       = 4'd8;
   localparam logic [3:0] ST_OUT       = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [AW-1:0]        scan_ff, scan_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 frac_ff, frac_in;
   logic                 err_ff, err_in;
   logic                 on_first_ff, on_first_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      idx_in      = idx_ff;
      frac_in     = frac_ff;
      err_in      = err_ff;
      on_first_in = on_first_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      rd_addr     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_x = 1'b1;
               if (req_action == ACT_LOAD) begin
                  cmd.knot_wr = 1'b1;
               end else if (status.cfg_error) begin
                  err_in   = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_CHK_FIRST;
               end
            end
         end
         ST_CHK_FIRST: begin
            // above the first knot: first temperature; on it, the last-knot clamp still wins
            rd_addr     = last_idx;
            cmd.hold_hi = 1'b1;
            idx_in      = '0;
            frac_in     = 1'b0;
            on_first_in = status.x_eq_knot;
            state_in    = (status.x_lt_knot || status.x_eq_knot) ? ST_CHK_LAST : ST_MUL_IDX;
         end
         ST_CHK_LAST: begin
            rd_addr = AW'(1);
            scan_in = AW'(1);
            if (status.x_lt_knot) begin
               idx_in   = last_idx;
               state_in = ST_MUL_IDX;
            end else if (on_first_ff) begin
               state_in = ST_MUL_IDX;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = scan_ff + AW'(1);
            if (!status.x_lt_knot) begin
               idx_in      = scan_ff - AW'(1);
               frac_in     = 1'b1;
               cmd.set_div = 1'b1;
               state_in    = ST_MUL_IDX;
            end else begin
               cmd.hold_hi = 1'b1;
               scan_in     = scan_ff + AW'(1);
            end
         end
         ST_MUL_IDX: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD_BASE;
         end
         ST_ADD_BASE: begin
            cmd.base_en = 1'b1;
            state_in    = frac_ff ? ST_MUL_FRAC : ST_OUT;
         end
         ST_MUL_FRAC: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_frac = 1'b1;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               cmd.out_err  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      err_ff      <= err_in;
      on_first_ff <= on_first_in;
      cnt_ff      <= cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign idx       = idx_ff;

`ifndef SYNTHESIS
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken item");

   a_err_to_out: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_CONVERT && status.cfg_error)
      |=> (state_ff == ST_OUT && err_ff))
      else $error("table error did not go straight to output");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_OUT))
      else $error("divider ran wrong number of steps");

   a_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

// File: rtl/sensor_table_interpolator.sv
// Sensor table interpolator: voltage to temperature over a falling knot table.
// Top level; instantiates sti_control and sti_datapath, uses sti_pkg.
//
// Usage:
//  - req channel (valid/ready): action 0 writes knot_voltage (100 uV units) at
//    knot_index, giving no result and leaving req_ready high; action 1 converts
//    sample_microvolts and gives exactly one rsp item.
//  - rsp channel (valid/ready): temperature, saturated at 65535, and
//    table_error (set, with temperature 0, for an empty table or a step
//    that is not positive).
//  - csr port: write-only, csr_index 0 point count, 1 first temperature,
//    2 second temperature; must be written only while the block is idle, a
//    user rule the block does not enforce. One item in flight: a table error
//    goes straight to the output load; other samples are checked against the
//    first knot and, unless above it, the last, searched knot by knot if in
//    between, then pass the index multiply, base add and, in a segment, the
//    fraction multiply and a 16-step restoring divide before the output load.
//  - The result sits in an output register; the next item is accepted while
//    it waits. A stalled receiver holds a finished convert in its last state.
//  - Reset clears the configuration, the control state and the handshakes;
//    knot memory is not cleared and must be loaded before use.
`default_nettype none

module sensor_table_interpolator
   import sti_pkg::*;
#(
   parameter int MAX_POINTS = STI_MAX_POINTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_action,
   input  wire logic [INDEX_W-1:0]    req_knot_index,
   input  wire logic [KNOT_W-1:0]     req_knot_voltage,
   input  wire logic [SAMPLE_W-1:0]   req_sample_microvolts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [TEMP_W-1:0]          rsp_temperature,
   output logic                       rsp_table_error,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_POINTS);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] idx;
   logic [AW-1:0] last_idx;

   sti_control #(
      .AW (AW)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .last_idx   (last_idx),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .idx        (idx)
   );

   sti_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .AW         (AW)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_knot_index        (req_knot_index),
      .req_knot_voltage      (req_knot_voltage),
      .req_sample_microvolts (req_sample_microvolts),
      .cmd                   (cmd),
      .rd_addr               (rd_addr),
      .idx                   (idx),
      .status                (status),
      .last_idx              (last_idx),
      .rsp_temperature       (rsp_temperature),
      .rsp_table_error       (rsp_table_error)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_sensor_table_interpolator.sv
// Self-checking testbench for sensor_table_interpolator: a directed table,
// then random knot tables and samples, checked against an in-bench predictor.
// Depends on sti_pkg and the sensor_table_interpolator RTL.
module tb_sensor_table_interpolator;
   import sti_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned QUIET_ITEMS  = 1050;
   localparam int unsigned HOLD_AFTER   = 300;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic              table_error;
   } reading_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      logic                  act;
      logic [INDEX_W-1:0]    idx;
      logic [KNOT_W-1:0]     volt;
      logic [SAMPLE_W-1:0]   sample;
      bit                    fixed;
      reading_type           want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_LOAD;
   logic [INDEX_W-1:0]    req_knot_index = '0;
   logic [KNOT_W-1:0]     req_knot_voltage = '0;
   logic [SAMPLE_W-1:0]   req_sample_microvolts = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TEMP_W-1:0]     rsp_temperature;
   logic                  rsp_table_error;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow state of the block
   logic [KNOT_W-1:0]  knot_mem [STI_MAX_POINTS];
   logic [COUNT_W-1:0] cfg_count;
   logic [TEMP_W-1:0]  cfg_first;
   logic [TEMP_W-1:0]  cfg_second;

   reading_type    pending_readings [$];
   reading_type    head;
   stim_row_type   directed_rows [$];
   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned items_accepted = 0;
   int unsigned conversions = 0;
   int unsigned error_results = 0;
   int unsigned knot_loads = 0;
   int unsigned settings = 0;
   bit          quiet = 1'b0;
   bit          hold_done = 1'b0;

   sensor_table_interpolator uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_knot_index        (req_knot_index),
      .req_knot_voltage      (req_knot_voltage),
      .req_sample_microvolts (req_sample_microvolts),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature       (rsp_temperature),
      .rsp_table_error       (rsp_table_error),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned knot_uv(input int unsigned i);
      return 64'(knot_mem[i]) * 64'(KNOT_SCALE);
   endfunction

   function automatic reading_type interpolate_temperature(input logic [SAMPLE_W-1:0] x);
      reading_type       r;
      int unsigned       n;
      int unsigned       idx;
      longint unsigned   step;
      longint unsigned   t;
      longint unsigned   hi;
      longint unsigned   lo;
      longint unsigned   xs;
      n = (32'(cfg_count) > STI_MAX_POINTS) ? STI_MAX_POINTS : 32'(cfg_count);
      r.temperature = '0;
      r.table_error = 1'b1;
      if (n == 0 || cfg_first >= cfg_second) return r;
      r.table_error = 1'b0;
      step = 64'(cfg_second) - 64'(cfg_first);
      xs = 64'(x);
      if (xs > knot_uv(0)) begin
         t = 64'(cfg_first);
      end else if (xs < knot_uv(n - 1)) begin
         t = 64'(cfg_first) + 64'(n - 1) * step;
      end else begin
         idx = 0;
         while (idx < n && xs < knot_uv(idx)) idx++;
         if (idx != 0) idx--;
         t = 64'(cfg_first) + 64'(idx) * step;
         if (idx != n - 1) begin
            hi = knot_uv(idx);
            lo = knot_uv(idx + 1);
            if (xs != hi && hi > lo && hi > xs) t += ((hi - xs) * step) / (hi - lo);
         end
      end
      r.temperature = (t > 64'(TEMP_MAX)) ? TEMP_MAX : t[TEMP_W-1:0];
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned n);
      longint unsigned hi_uv;
      longint unsigned lo_uv;
      logic [31:0]     v;
      hi_uv = knot_uv(0);
      lo_uv = knot_uv(n - 1);
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = 32'(knot_uv($urandom_range(0, n - 1)));
         2: v = (hi_uv < 64'hFFFFFF) ? $urandom_range(32'(hi_uv) + 32'd1, 32'hFFFFFF)
                                     : $urandom;
         3: v = (lo_uv > 0) ? $urandom_range(32'd0, 32'(lo_uv) - 32'd1) : 32'd0;
         default: v = $urandom_range(32'(lo_uv), 32'(hi_uv));
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                            input logic [KNOT_W-1:0] volt, input logic [SAMPLE_W-1:0] sample,
                            input bit fixed, input reading_type want);
      reading_type r;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_action            <= act;
      req_knot_index        <= idx;
      req_knot_voltage      <= volt;
      req_sample_microvolts <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_accepted++;
      if (act == ACT_LOAD) begin
         knot_mem[idx] = volt;
         knot_loads++;
      end else begin
         r = fixed ? want : interpolate_temperature(sample);
         pending_readings.push_back(r);
         conversions++;
         if (r.table_error) error_results++;
      end
   endtask

   task automatic wait_quiescent();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_POINT_COUNT: cfg_count  = value[COUNT_W-1:0];
         CSR_FIRST_TEMP:  cfg_first  = value;
         CSR_SECOND_TEMP: cfg_second = value;
         default: ;
      endcase
   endtask

   task automatic load_table(input int unsigned n, input bit scrambled);
      int unsigned v;
      int unsigned drop;
      int unsigned max_drop;
      int unsigned i;
      int unsigned r;
      max_drop = 65535 / n;
      v = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(n * 100, 65535);
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 65535);
         send_item(ACT_LOAD, i[INDEX_W-1:0], scrambled ? r[15:0] : v[15:0],
                   SAMPLE_W'($urandom), 1'b0, '0);
         drop = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, max_drop);
         v = (v > drop) ? v - drop : 0;
      end
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = v;
      directed_rows.push_back(row);
   endtask

   task automatic add_load(input logic [INDEX_W-1:0] idx, input logic [KNOT_W-1:0] v);
      stim_row_type row;
      row = '{default: '0};
      row.act  = ACT_LOAD;
      row.idx  = idx;
      row.volt = v;
      directed_rows.push_back(row);
   endtask

   task automatic add_convert(input logic [SAMPLE_W-1:0] x, input bit fixed,
                              input logic [TEMP_W-1:0] t, input logic e);
      stim_row_type row;
      row = '{default: '0};
      row.act    = ACT_CONVERT;
      row.sample = x;
      row.fixed  = fixed;
      row.want   = '{temperature: t, table_error: e};
      directed_rows.push_back(row);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            note_failure($sformatf("unexpected result: temperature %0d error %0b",
                                   rsp_temperature, rsp_table_error));
         end else begin
            head = pending_readings.pop_front();
            if (head.temperature !== rsp_temperature || head.table_error !== rsp_table_error)
               note_failure($sformatf("mismatch: expected temperature %0d error %0b, got %0d %0b",
                                      head.temperature, head.table_error,
                                      rsp_temperature, rsp_table_error));
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned  directed_items;
      int unsigned  n;
      int unsigned  first_t;
      int unsigned  second_t;
      int unsigned  count_v;
      bit           usable;
      bit           prev_csr;
      stim_row_type row;

      cfg_count  = '0;
      cfg_first  = '0;
      cfg_second = '0;

      // empty table straight after reset
      add_convert(24'd0, 1'b1, 16'd0, 1'b1);
      add_csr(CSR_POINT_COUNT, 16'd4);
      add_csr(CSR_FIRST_TEMP, 16'd100);
      add_csr(CSR_SECOND_TEMP, 16'd110);
      add_load(6'd0, 16'd50000);
      add_load(6'd1, 16'd40000);
      add_load(6'd2, 16'd30000);
      add_load(6'd3, 16'd20000);
      add_convert(24'hFFFFFF, 1'b1, 16'd100, 1'b0);
      add_convert(24'd0, 1'b1, 16'd130, 1'b0);
      add_convert(24'd5000000, 1'b1, 16'd100, 1'b0);
      add_convert(24'd4500000, 1'b0, 16'd0, 1'b0);
      add_convert(24'd2000000, 1'b1, 16'd130, 1'b0);
      add_convert(24'd3000000, 1'b1, 16'd120, 1'b0);
      // flat segment
      add_load(6'd2, 16'd40000);
      add_convert(24'd4000000, 1'b0, 16'd0, 1'b0);
      add_convert(24'd3500000, 1'b0, 16'd0, 1'b0);
      // zero and negative step
      add_csr(CSR_SECOND_TEMP, 16'd100);
      add_convert(24'd4500000, 1'b1, 16'd0, 1'b1);
      add_csr(CSR_SECOND_TEMP, 16'd90);
      add_convert(24'd4500000, 1'b1, 16'd0, 1'b1);
      // saturation
      add_csr(CSR_FIRST_TEMP, 16'd65000);
      add_csr(CSR_SECOND_TEMP, 16'd65535);
      add_convert(24'd0, 1'b1, 16'hFFFF, 1'b0);
      add_convert(24'd2500000, 1'b0, 16'd0, 1'b0);
      // single knot
      add_csr(CSR_POINT_COUNT, 16'd1);
      add_csr(CSR_FIRST_TEMP, 16'd0);
      add_convert(24'd5000000, 1'b1, 16'd0, 1'b0);
      add_convert(24'd0, 1'b1, 16'd0, 1'b0);
      add_convert(24'hFFFFFF, 1'b1, 16'd0, 1'b0);
      add_load(6'd63, 16'hFFFF);
      add_load(6'd63, 16'd0);
      add_csr(CSR_POINT_COUNT, 16'd0);
      add_convert(24'd123, 1'b1, 16'd0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_csr = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            if (!prev_csr) wait_quiescent();
            write_register(row.csr_idx, row.csr_val);
         end else begin
            send_item(row.act, row.idx, row.volt, row.sample, row.fixed, row.want);
         end
         prev_csr = row.is_csr;
      end
      directed_items = items_accepted;

      while (items_accepted - directed_items < RANDOM_ITEMS) begin
         wait_quiescent();
         case ($urandom_range(0, 9))
            0: count_v = 0;
            1: count_v = 1;
            2: count_v = 64;
            3: count_v = $urandom_range(65, 127);
            4: count_v = 127;
            default: count_v = $urandom_range(2, 8);
         endcase
         case ($urandom_range(0, 7))
            0: begin
               first_t  = $urandom_range(0, 65535);
               second_t = first_t;
            end
            1: begin
               first_t  = $urandom_range(1, 65535);
               second_t = $urandom_range(0, first_t - 1);
            end
            2: begin
               first_t  = 0;
               second_t = 65535;
            end
            3: begin
               first_t  = 65534;
               second_t = 65535;
            end
            4: begin
               first_t  = $urandom_range(0, 65534);
               second_t = $urandom_range(first_t + 1, 65535);
            end
            default: begin
               first_t  = $urandom_range(0, 60000);
               second_t = first_t + $urandom_range(1, 2000);
            end
         endcase
         write_register(CSR_POINT_COUNT, count_v[CSR_DATA_W-1:0]);
         write_register(CSR_FIRST_TEMP, first_t[CSR_DATA_W-1:0]);
         write_register(CSR_SECOND_TEMP, second_t[CSR_DATA_W-1:0]);
         settings++;
         n = (count_v > STI_MAX_POINTS) ? STI_MAX_POINTS : count_v;
         usable = (n != 0 && first_t < second_t);
         if (usable) load_table(n, $urandom_range(0, 5) == 0);
         repeat ($urandom_range(20, 60)) begin
            quiet = (items_accepted - directed_items >= QUIET_ITEMS);
            if ($urandom_range(0, 6) == 0)
               send_item(ACT_LOAD, INDEX_W'($urandom), KNOT_W'($urandom),
                         SAMPLE_W'($urandom), 1'b0, '0);
            else
               send_item(ACT_CONVERT, INDEX_W'($urandom), KNOT_W'($urandom),
                         usable ? pick_sample(n) : SAMPLE_W'($urandom), 1'b0, '0);
         end
      end

      wait_quiescent();
      if (pending_readings.size() != 0)
         note_failure($sformatf("%0d results never arrived", pending_readings.size()));
      $display("Ran %0d items: %0d conversions (%0d flagged), %0d knot loads, %0d settings",
               items_accepted, conversions, error_results, knot_loads, settings + 1);
      $display("Covered clamps, flat segments, saturation, count overflow and a long stall");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
